### design/ihc_pkg.sv
// Package for the IPv4 header checker: widths, header word positions, verdict
// codes, register indexes, the latched header and result records, and the
// ones' complement add. No dependencies.
package ihc_pkg;

	localparam int HEADER_WORDS = 10;
	localparam int IDX_W        = 4;
	localparam int WORD_W       = 16;
	localparam int ADDR_W       = 32;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;
	localparam int OUT_TDATA_W  = 72;

	// verdict codes
	localparam logic [1:0] VERDICT_OK          = 2'd0;
	localparam logic [1:0] VERDICT_BAD_VERSION = 2'd1;
	localparam logic [1:0] VERDICT_BAD_DEST    = 2'd2;
	localparam logic [1:0] VERDICT_BAD_SUM     = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd1;

	localparam logic [ADDR_W-1:0] OWN_ADDRESS_RESET = 32'hC0A8_010C;
	localparam logic [WORD_W-1:0] MAX_PAYLOAD_RESET = 16'd65515;

	localparam logic [7:0]        VERSION_IHL_OK    = 8'h45;
	localparam logic [WORD_W-1:0] BASE_HEADER_BYTES = 16'd20;
	localparam logic [WORD_W-1:0] SUM_ALL_ONES      = 16'hFFFF;

	// header word positions
	localparam logic [IDX_W-1:0] WORD_VERSION   = 4'd0;
	localparam logic [IDX_W-1:0] WORD_LENGTH    = 4'd1;
	localparam logic [IDX_W-1:0] WORD_TTL_PROTO = 4'd4;
	localparam logic [IDX_W-1:0] WORD_SRC_HI    = 4'd6;
	localparam logic [IDX_W-1:0] WORD_SRC_LO    = 4'd7;
	localparam logic [IDX_W-1:0] WORD_DST_HI    = 4'd8;
	localparam logic [IDX_W-1:0] WORD_DST_LO    = 4'd9;
	localparam logic [IDX_W-1:0] WORD_COUNT     = IDX_W'(HEADER_WORDS);

	typedef struct packed {
		logic [7:0]        version_byte;
		logic [WORD_W-1:0] total_length;
		logic [7:0]        ttl_value;
		logic [7:0]        protocol_value;
		logic [ADDR_W-1:0] source_value;
		logic [ADDR_W-1:0] dest_value;
		logic [WORD_W-1:0] running_sum;
	} hdr_t;

	// first member lands in the highest bits: verdict sits at bit 0
	typedef struct packed {
		logic              payload_fits;
		logic [WORD_W-1:0] payload_length;
		logic [7:0]        ttl_next;
		logic [7:0]        protocol_number;
		logic [ADDR_W-1:0] source_address;
		logic [1:0]        verdict;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

	function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
	endfunction

endpackage

### design/ihc_verdict.sv
// Final decision for one complete header: verdict in priority order and the
// payload length check. Depends on ihc_pkg.
module ihc_verdict
	import ihc_pkg::*;
(
	input  hdr_t              hdr,
	input  logic [ADDR_W-1:0] own_address,
	input  logic [WORD_W-1:0] max_payload,
	output result_t           result
);

	logic [WORD_W-1:0] plen;
	logic              underflow;
	logic              too_long;

	assign underflow = hdr.total_length < BASE_HEADER_BYTES;
	assign plen      = hdr.total_length - BASE_HEADER_BYTES;
	assign too_long  = plen > max_payload;

	always_comb begin
		if (hdr.version_byte != VERSION_IHL_OK) begin
			result.verdict = VERDICT_BAD_VERSION;
		end else if (hdr.dest_value != own_address) begin
			result.verdict = VERDICT_BAD_DEST;
		end else if (hdr.running_sum != SUM_ALL_ONES) begin
			result.verdict = VERDICT_BAD_SUM;
		end else begin
			result.verdict = VERDICT_OK;
		end
		result.source_address  = hdr.source_value;
		result.protocol_number = hdr.protocol_value;
		result.ttl_next        = hdr.ttl_value - 8'd1;
		result.payload_fits    = !underflow && !too_long;
		result.payload_length  = (underflow || too_long) ? '0 : plen;
	end

endmodule

### design/ipv4_header_checker.sv
// IPv4 header checker. Takes one 16-bit header word per beat (s_tuser marks the
// first word of a header) and, after the tenth word, reports in one result beat the
// verdict with source, protocol, decremented TTL and payload length. The tenth word
// is held in the input register while the checksum fold and the compares run from
// it, and the result register loads from their outcome. A new word is taken every cycle;
// the input stalls only when the last word of a header meets a result beat that is
// still waiting downstream.
// Depends on ihc_pkg and ihc_verdict.
module ipv4_header_checker
	import ihc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// header word stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [WORD_W-1:0]      s_tdata,   // [15:0] header_word
	input  logic                   s_tuser,   // [0] start_flag
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [1:0] verdict, [33:2] source_address, [41:34] protocol_number,
	// [49:42] ttl_next, [65:50] payload_length, [66] payload_fits, rest zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// register writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [ADDR_W-1:0] own_address_q;
	logic [WORD_W-1:0] max_payload_q;

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              start_s1;

	logic [IDX_W-1:0]  word_index_q;
	hdr_t              hdr_q;

	logic              out_valid_q;
	result_t           out_data_q;

	logic              restart;
	logic [IDX_W-1:0]  idx_eff;
	logic              is_last;
	logic              advance;
	logic              take;
	hdr_t              hdr_next;
	result_t           result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= OWN_ADDRESS_RESET;
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OWN_ADDRESS: own_address_q <= cfg_data;
				CFG_MAX_PAYLOAD: max_payload_q <= cfg_data[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	// a start word or a finished count restarts the header
	assign restart = start_s1 || (word_index_q >= WORD_COUNT);
	assign idx_eff = restart ? '0 : word_index_q;
	assign is_last = idx_eff == WORD_DST_LO;

	// hold the last word only while a result beat is still pending
	assign advance  = !valid_s1 || !is_last || !out_valid_q || m_tready;
	assign take     = valid_s1 && advance;
	assign s_tready = advance;

	always_comb begin
		hdr_next             = hdr_q;
		hdr_next.running_sum = ones_add(restart ? '0 : hdr_q.running_sum, word_s1);
		unique case (idx_eff)
			WORD_VERSION:   hdr_next.version_byte = word_s1[15:8];
			WORD_LENGTH:    hdr_next.total_length = word_s1;
			WORD_TTL_PROTO: begin
				hdr_next.ttl_value      = word_s1[15:8];
				hdr_next.protocol_value = word_s1[7:0];
			end
			WORD_SRC_HI:    hdr_next.source_value[31:16] = word_s1;
			WORD_SRC_LO:    hdr_next.source_value[15:0]  = word_s1;
			WORD_DST_HI:    hdr_next.dest_value[31:16]   = word_s1;
			WORD_DST_LO:    hdr_next.dest_value[15:0]    = word_s1;
			default: ;
		endcase
	end

	ihc_verdict u_verdict (
		.hdr         (hdr_next),
		.own_address (own_address_q),
		.max_payload (max_payload_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_index_q <= '0;
			hdr_q        <= '0;
		end else if (take) begin
			word_index_q <= is_last ? '0 : idx_eff + IDX_W'(1);
			hdr_q        <= hdr_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && is_last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_last) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_data_q};

endmodule

### design/ihc_checker.sv
// Port-level checks for the IPv4 header checker, bound to the top level.
// Depends on ihc_pkg and ipv4_header_checker.
module ihc_checker
	import ihc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// a stalled result beat holds its data
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// the input stalls only behind a blocked result
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a blocked result");

	// a new result follows an accepted header word, through the input and result registers
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a preceding header word");

	// a payload that does not fit reports length zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[66] |-> m_tdata[65:50] == '0)
		else $error("nonzero length on a payload that does not fit");

endmodule

bind ipv4_header_checker ihc_checker u_ihc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### verif/tb_ipv4_header_checker.sv
// Testbench for ipv4_header_checker: drives header word streams and register writes,
// predicts each verdict beat and compares it field by field.
// Depends on ihc_pkg and the ipv4_header_checker RTL.
`timescale 1ns / 1ps

module tb_ipv4_header_checker;
	import ihc_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 10;
	localparam int PHASE_WORDS   = 277;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	// Keeps its own copy of the header state and registers, and the queue of
	// verdict beats that accepted words have made due.
	class header_verdict_board;
		logic [ADDR_W-1:0] own_addr;
		logic [WORD_W-1:0] max_pay;
		logic [IDX_W-1:0]  word_count;
		logic [WORD_W-1:0] csum;
		logic [7:0]        ver_ihl;
		logic [WORD_W-1:0] tot_len;
		logic [7:0]        ttl;
		logic [7:0]        proto;
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		result_t           verdicts_due[$];
		int                mismatches;

		function new();
			own_addr   = OWN_ADDRESS_RESET;
			max_pay    = MAX_PAYLOAD_RESET;
			word_count = '0;
			csum       = '0;
			ver_ihl    = '0;
			tot_len    = '0;
			ttl        = '0;
			proto      = '0;
			src        = '0;
			dst        = '0;
			mismatches = 0;
		endfunction

		static function logic [WORD_W-1:0] fold_add(input logic [WORD_W-1:0] a,
				input logic [WORD_W-1:0] b);
			logic [WORD_W:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[WORD_W-1:0] + WORD_W'(s[WORD_W]);
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_OWN_ADDRESS: own_addr = data;
				CFG_MAX_PAYLOAD: max_pay = data[WORD_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction

		function void take_word(input logic [WORD_W-1:0] w, input logic first);
			result_t r;
			if (first || word_count >= HEADER_WORDS) begin
				word_count = '0;
				csum = '0;
			end
			csum = fold_add(csum, w);
			case (word_count)
				WORD_VERSION:   ver_ihl = w[15:8];
				WORD_LENGTH:    tot_len = w;
				WORD_TTL_PROTO: begin
					ttl = w[15:8];
					proto = w[7:0];
				end
				WORD_SRC_HI:    src[31:16] = w;
				WORD_SRC_LO:    src[15:0] = w;
				WORD_DST_HI:    dst[31:16] = w;
				WORD_DST_LO:    dst[15:0] = w;
				default: ;
			endcase
			word_count = word_count + 1'b1;
			if (word_count < HEADER_WORDS)
				return;
			word_count = '0;

			if (ver_ihl != VERSION_IHL_OK)
				r.verdict = VERDICT_BAD_VERSION;
			else if (dst != own_addr)
				r.verdict = VERDICT_BAD_DEST;
			else if (csum != SUM_ALL_ONES)
				r.verdict = VERDICT_BAD_SUM;
			else
				r.verdict = VERDICT_OK;
			r.source_address  = src;
			r.protocol_number = proto;
			r.ttl_next        = ttl - 8'd1;
			if (tot_len < BASE_HEADER_BYTES) begin
				r.payload_length = '0;
				r.payload_fits   = 1'b0;
			end else if (tot_len - BASE_HEADER_BYTES > max_pay) begin
				r.payload_length = '0;
				r.payload_fits   = 1'b0;
			end else begin
				r.payload_length = tot_len - BASE_HEADER_BYTES;
				r.payload_fits   = 1'b1;
			end
			verdicts_due.push_back(r);
		endfunction

		function void flag(input string field, input logic [63:0] want, input logic [63:0] got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
		endfunction

		function void match_result(input logic [OUT_TDATA_W-1:0] tdata);
			result_t got;
			result_t want;
			got = tdata[RESULT_W-1:0];
			if (verdicts_due.size() == 0) begin
				flag("unexpected beat", 64'd0, 64'(tdata));
				return;
			end
			want = verdicts_due.pop_front();
			if (got.verdict !== want.verdict)
				flag("verdict", 64'(want.verdict), 64'(got.verdict));
			if (got.source_address !== want.source_address)
				flag("source_address", 64'(want.source_address), 64'(got.source_address));
			if (got.protocol_number !== want.protocol_number)
				flag("protocol_number", 64'(want.protocol_number), 64'(got.protocol_number));
			if (got.ttl_next !== want.ttl_next)
				flag("ttl_next", 64'(want.ttl_next), 64'(got.ttl_next));
			if (got.payload_length !== want.payload_length)
				flag("payload_length", 64'(want.payload_length), 64'(got.payload_length));
			if (got.payload_fits !== want.payload_fits)
				flag("payload_fits", 64'(want.payload_fits), 64'(got.payload_fits));
			if (tdata[OUT_TDATA_W-1:RESULT_W] !== '0)
				flag("padding", 64'd0, 64'(tdata[OUT_TDATA_W-1:RESULT_W]));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [WORD_W-1:0]      s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	header_verdict_board sb = new();
	logic [WORD_W-1:0] hdr[HEADER_WORDS];
	bit no_idle = 1'b0;
	int words_sent = 0;

	ipv4_header_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int draw_wait();
		return no_idle ? 0 : int'($urandom_range(0, 8));
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_word(input logic [WORD_W-1:0] w, input logic first);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
		sb.take_word(w, first);
		words_sent++;
	endtask

	task automatic build_header(input logic [7:0] ver, input logic [15:0] tot,
			input logic [7:0] ttl, input logic [7:0] proto, input logic [31:0] src,
			input logic [31:0] dst, input bit good_sum);
		logic [WORD_W-1:0] s;
		hdr[0] = {ver, 8'($urandom)};
		hdr[1] = tot;
		hdr[2] = 16'($urandom);
		hdr[3] = 16'($urandom);
		hdr[4] = {ttl, proto};
		hdr[5] = '0;
		hdr[6] = src[31:16];
		hdr[7] = src[15:0];
		hdr[8] = dst[31:16];
		hdr[9] = dst[15:0];
		s = '0;
		for (int i = 0; i < HEADER_WORDS; i++)
			if (i != 5)
				s = header_verdict_board::fold_add(s, hdr[i]);
		// with a good sum the checksum word is the complement of everything else
		hdr[5] = good_sum ? ~s : ~s ^ 16'($urandom_range(1, 65535));
	endtask

	task automatic send_header(input int count, input bit lead, input bit noisy);
		for (int i = 0; i < count; i++)
			send_word(hdr[i], (i == 0) ? lead : (noisy && $urandom_range(0, 49) == 0));
	endtask

	// hold the sender until every verdict is out and the pipeline is empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_header();
		logic [7:0]  ver;
		logic [15:0] tot;
		logic [31:0] dst;
		int          lim;
		int          count;
		if ($urandom_range(0, 15) == 0)
			no_idle = ~no_idle;
		ver = ($urandom_range(0, 4) != 0) ? VERSION_IHL_OK : 8'($urandom);
		dst = ($urandom_range(0, 9) < 8) ? sb.own_addr : $urandom;
		case ($urandom_range(0, 3))
			0: tot = 16'($urandom);
			1: tot = 16'($urandom_range(0, 24));
			2: begin
				lim = int'(sb.max_pay) + 18 + int'($urandom_range(0, 4));
				tot = (lim > 65535) ? 16'hFFFF : 16'(lim);
			end
			default: tot = 16'($urandom_range(20, 1520));
		endcase
		build_header(ver, tot, 8'($urandom), 8'($urandom), $urandom, dst,
			$urandom_range(0, 4) != 0);
		count = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 9)) : HEADER_WORDS;
		send_header(count, $urandom_range(0, 9) != 0, 1'b1);
	endtask

	task automatic random_phase(input logic [31:0] own, input logic [15:0] max_len);
		int target;
		settle();
		write_reg(CFG_OWN_ADDRESS, own);
		if ($urandom_range(0, 1) == 1)
			write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
		write_reg(CFG_MAX_PAYLOAD, {16'($urandom), max_len});
		target = words_sent + PHASE_WORDS;
		while (words_sent < target)
			random_header();
	endtask

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.match_result(m_tdata);

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// writes to unused indexes must leave the registers alone
		write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);

		// clean header with reset settings: widest length fits exactly, TTL wraps
		build_header(VERSION_IHL_OK, 16'hFFFF, 8'h00, 8'hFF, 32'hFFFF_FFFF,
			sb.own_addr, 1'b1);
		send_header(HEADER_WORDS, 1'b1, 1'b0);
		build_header(8'h46, 16'd19, 8'h40, 8'h06, 32'h0A00_0001, sb.own_addr, 1'b1);
		send_header(HEADER_WORDS, 1'b1, 1'b0);
		build_header(VERSION_IHL_OK, 16'd20, 8'h80, 8'h11, 32'h1234_5678,
			sb.own_addr ^ 32'h1, 1'b1);
		send_header(HEADER_WORDS, 1'b1, 1'b0);
		build_header(VERSION_IHL_OK, 16'd0, 8'h01, 8'h01, 32'h8000_0000, sb.own_addr, 1'b0);
		send_header(HEADER_WORDS, 1'b1, 1'b0);
		// cut a header short, restart with the start flag
		send_header(4, 1'b1, 1'b0);
		build_header(VERSION_IHL_OK, 16'd1500, 8'h01, 8'h11, 32'h0000_0001, sb.own_addr, 1'b1);
		send_header(HEADER_WORDS, 1'b1, 1'b0);
		// a finished header leaves the count at zero, so no start flag is needed
		build_header(VERSION_IHL_OK, 16'd64, 8'hFF, 8'h00, 32'h0, sb.own_addr, 1'b1);
		send_header(HEADER_WORDS, 1'b0, 1'b0);

		settle();
		write_reg(CFG_OWN_ADDRESS, 32'h0);
		write_reg(CFG_SPARE_B, 32'h0);
		write_reg(CFG_MAX_PAYLOAD, 32'd100);
		build_header(VERSION_IHL_OK, 16'd121, 8'h20, 8'h06, $urandom, 32'h0, 1'b1);
		send_header(HEADER_WORDS, 1'b1, 1'b0);
		build_header(VERSION_IHL_OK, 16'd120, 8'h20, 8'h06, $urandom, 32'h0, 1'b1);
		send_header(HEADER_WORDS, 1'b1, 1'b0);

		random_phase($urandom, 16'd0);
		random_phase(32'hFFFF_FFFF, 16'hFFFF);
		random_phase(32'h0, 16'($urandom));
		random_phase($urandom, 16'($urandom_range(0, 1500)));
		random_phase(OWN_ADDRESS_RESET, MAX_PAYLOAD_RESET);

		settle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
